// ===== sv/ledd_pkg.sv =====
// Shared types and constants for the addressable LED bit-slot driver.
package ledd_pkg;

    // Number of LEDs on the string.
    localparam int LED_COUNT    = 16;
    localparam int BITS_PER_LED = 24;
    localparam int DATA_SLOTS   = LED_COUNT * BITS_PER_LED;

    // Widths; the LED index, counter and slot position widths derive from the LED count.
    localparam int LED_AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int CNT_W  = $clog2(LED_COUNT + 1);
    localparam int CFG_W  = 10;
    localparam int POS_W  = $clog2(DATA_SLOTS + (1 << CFG_W));
    localparam int BIT_W  = 5;
    localparam int GRB_W  = 24;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DUTY_ONE    = 2'd0;
    localparam logic [1:0] CFG_DUTY_ZERO   = 2'd1;
    localparam logic [1:0] CFG_RESET_SLOTS = 2'd2;

    // Register reset values.
    localparam logic [CFG_W-1:0] DUTY_ONE_RST    = 10'd67;
    localparam logic [CFG_W-1:0] DUTY_ZERO_RST   = 10'd34;
    localparam logic [CFG_W-1:0] RESET_SLOTS_RST = 10'd64;

    // Item function codes.
    typedef enum logic [2:0] {
        FN_WRITE = 3'd0,
        FN_FILL  = 3'd1,
        FN_CLEAR = 3'd2,
        FN_START = 3'd3,
        FN_TICK  = 3'd4
    } t_func;

    // Control from the sequencer to the bit serializer.
    typedef struct packed {
        logic restart;
        logic load;
        logic emit;
    } t_ser_ctl;

    // Status from the bit serializer to the sequencer.
    typedef struct packed {
        logic              need_word;
        logic              last;
        logic [LED_AW-1:0] led;
    } t_ser_sts;

endpackage

// ===== sv/ledd_slot_ser.sv =====
// Bit serializer: shifts one pixel word out MSB first and tracks the slot position.
module ledd_slot_ser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ledd_pkg::t_ser_ctl    i_ctl,
    input  logic [23:0]           i_word,
    input  logic [9:0]            i_duty_one,
    input  logic [9:0]            i_duty_zero,
    input  logic [9:0]            i_reset_slots,
    output ledd_pkg::t_ser_sts    o_sts,
    output logic [9:0]            o_duty
);
    import ledd_pkg::*;

    logic [POS_W-1:0]  r_pos;
    logic [BIT_W-1:0]  r_bit;
    logic [LED_AW-1:0] r_led;
    logic [GRB_W-1:0]  r_shift;
    logic              in_data;
    logic [POS_W:0]    total;
    logic [POS_W:0]    pos_next;

    // Slot classification and end-of-frame compare against the live reset count.
    always_comb begin
        in_data  = r_pos < POS_W'(DATA_SLOTS);
        total    = (POS_W + 1)'(DATA_SLOTS) + (POS_W + 1)'(i_reset_slots);
        pos_next = {1'b0, r_pos} + (POS_W + 1)'(1);
        o_sts.last      = pos_next >= total;
        o_sts.need_word = in_data && (r_bit == '0);
        o_sts.led       = r_led;
        o_duty = in_data ? (r_shift[GRB_W-1] ? i_duty_one : i_duty_zero) : '0;
    end

    // Position counters: slot, bit within the LED, and LED.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_bit <= '0;
            r_led <= '0;
        end else if (i_ctl.restart) begin
            r_pos <= '0;
            r_bit <= '0;
            r_led <= '0;
        end else if (i_ctl.emit) begin
            if (o_sts.last) begin
                r_pos <= '0;
                r_bit <= '0;
                r_led <= '0;
            end else begin
                r_pos <= pos_next[POS_W-1:0];
                if (in_data) begin
                    if (r_bit == BIT_W'(BITS_PER_LED - 1)) begin
                        r_bit <= '0;
                        r_led <= r_led + LED_AW'(1);
                    end else begin
                        r_bit <= r_bit + BIT_W'(1);
                    end
                end
            end
        end
    end

    // Pixel shift register, one bit leaves per data slot.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_shift <= i_word;
        end else if (i_ctl.emit && in_data) begin
            r_shift <= {r_shift[GRB_W-2:0], 1'b0};
        end
    end

endmodule

// ===== sv/addressable_led_bit_slot_driver.sv =====
// Top level of the addressable LED bit-slot driver: pixel store, frame copy and slot sequencer.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------------------
//  item    | in        | i_valid / o_stall      | i_func, i_pixel_index, i_red, i_green, i_blue
//  result  | out       | o_valid / i_stall      | o_slot_duty, o_slot_valid, o_frame_done,
//          |           |                        | o_busy_flag, o_accepted
//  config  | in        | i_cfg_we (no wait)     | i_cfg_idx, i_cfg_data
//
// One item is worked on at a time. Write, clear, unknown codes and idle ticks pass through the
// exec and finish states; a tick while sending also passes the emit state, and the load state
// before it when a new pixel word is read from the frame copy. Fill walks the store one pixel a
// cycle, and start copies store to frame copy one pixel a cycle; fill uses the single store
// write port and start the single store read port. Reset is synchronous; the store reads as
// zero through per-pixel valid bits. A new item is taken while a finished result still waits
// on a stalled output; the next result waits in a holding register.
module addressable_led_bit_slot_driver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_func,
    input  logic [7:0] i_pixel_index,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [9:0] o_slot_duty,
    output logic       o_slot_valid,
    output logic       o_frame_done,
    output logic       o_busy_flag,
    output logic       o_accepted,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [9:0] i_cfg_data
);
    import ledd_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FILL,
        S_COPY,
        S_LOAD,
        S_EMIT,
        S_FIN
    } t_state;

    t_state            r_state;
    logic              r_sending;
    logic [CNT_W-1:0]  r_cnt;
    t_func             r_func;
    logic [7:0]        r_idx;
    logic [GRB_W-1:0]  r_grb;
    logic [CFG_W-1:0]  r_duty_one;
    logic [CFG_W-1:0]  r_duty_zero;
    logic [CFG_W-1:0]  r_reset_slots;
    logic [CFG_W-1:0]  r_res_duty;
    logic              r_res_valid;
    logic              r_res_done;
    logic              r_res_acc;

    // Pixel store and frame copy.
    logic [GRB_W-1:0]     r_store [LED_COUNT];
    logic [LED_COUNT-1:0] r_store_vld;
    logic [GRB_W-1:0]     r_store_rd;
    logic                 r_store_rv;
    logic [GRB_W-1:0]     r_snap [LED_COUNT];
    logic [GRB_W-1:0]     r_snap_rd;

    logic              idx_ok;
    logic              store_we;
    logic [LED_AW-1:0] store_wa;
    logic              snap_we;
    logic [LED_AW-1:0] snap_wa;
    logic [CNT_W-1:0]  cnt_prev;
    logic              copy_end;
    t_ser_ctl          ser_ctl;
    t_ser_sts          ser_sts;
    logic [CFG_W-1:0]  ser_duty;

    assign o_stall = (r_state != S_IDLE);

    // Memory port selection and serializer control.
    always_comb begin
        idx_ok   = r_idx < 8'(LED_COUNT);
        store_we = (r_state == S_FILL) ||
                   ((r_state == S_EXEC) && (r_func == FN_WRITE) && idx_ok);
        store_wa = (r_state == S_FILL) ? r_cnt[LED_AW-1:0] : r_idx[LED_AW-1:0];
        cnt_prev = r_cnt - CNT_W'(1);
        snap_wa  = cnt_prev[LED_AW-1:0];
        snap_we  = (r_state == S_COPY) && (r_cnt != '0);
        copy_end = (r_state == S_COPY) && (r_cnt == CNT_W'(LED_COUNT));
        ser_ctl.restart = copy_end;
        ser_ctl.load    = (r_state == S_LOAD);
        ser_ctl.emit    = (r_state == S_EMIT);
    end

    // Pixel store: one write port, one registered read port for the frame copy.
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[store_wa] <= r_grb;
        end
        r_store_rd <= r_store[r_cnt[LED_AW-1:0]];
    end

    // Per-pixel valid bits; a pixel never written since clear reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_store_vld <= '0;
            r_store_rv  <= 1'b0;
        end else begin
            r_store_rv <= r_store_vld[r_cnt[LED_AW-1:0]];
            if ((r_state == S_EXEC) && (r_func == FN_CLEAR)) begin
                r_store_vld <= '0;
            end else if (store_we) begin
                r_store_vld[store_wa] <= 1'b1;
            end
        end
    end

    // Frame copy: filled during start, read one word per LED while sending.
    always_ff @(posedge i_clk) begin
        if (snap_we) begin
            r_snap[snap_wa] <= r_store_rv ? r_store_rd : '0;
        end
        r_snap_rd <= r_snap[ser_sts.led];
    end

    ledd_slot_ser u_ser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ser_ctl),
        .i_word        (r_snap_rd),
        .i_duty_one    (r_duty_one),
        .i_duty_zero   (r_duty_zero),
        .i_reset_slots (r_reset_slots),
        .o_sts         (ser_sts),
        .o_duty        (ser_duty)
    );

    // Sequencer, configuration registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_sending     <= 1'b0;
            r_cnt         <= '0;
            r_duty_one    <= DUTY_ONE_RST;
            r_duty_zero   <= DUTY_ZERO_RST;
            r_reset_slots <= RESET_SLOTS_RST;
            o_valid       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_DUTY_ONE:    r_duty_one    <= i_cfg_data;
                    CFG_DUTY_ZERO:   r_duty_zero   <= i_cfg_data;
                    CFG_RESET_SLOTS: r_reset_slots <= i_cfg_data;
                    default: ;
                endcase
            end
            if (o_valid && !i_stall && (r_state != S_FIN)) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_func  <= t_func'(i_func);
                        r_idx   <= i_pixel_index;
                        r_grb   <= {i_green, i_red, i_blue};
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_cnt       <= '0;
                    r_res_duty  <= '0;
                    r_res_valid <= 1'b0;
                    r_res_done  <= 1'b0;
                    case (r_func)
                        FN_WRITE: begin
                            r_res_acc <= idx_ok;
                            r_state   <= S_FIN;
                        end
                        FN_FILL: begin
                            r_res_acc <= 1'b1;
                            r_state   <= S_FILL;
                        end
                        FN_CLEAR: begin
                            r_res_acc <= 1'b1;
                            r_state   <= S_FIN;
                        end
                        FN_START: begin
                            if (r_sending) begin
                                r_res_acc <= 1'b0;
                                r_state   <= S_FIN;
                            end else begin
                                r_res_acc <= 1'b1;
                                r_state   <= S_COPY;
                            end
                        end
                        FN_TICK: begin
                            r_res_acc <= 1'b1;
                            if (!r_sending) begin
                                r_state <= S_FIN;
                            end else if (ser_sts.need_word) begin
                                r_state <= S_LOAD;
                            end else begin
                                r_state <= S_EMIT;
                            end
                        end
                        default: begin
                            r_res_acc <= 1'b0;
                            r_state   <= S_FIN;
                        end
                    endcase
                end
                S_FILL: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(LED_COUNT - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_COPY: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (copy_end) begin
                        r_sending <= 1'b1;
                        r_state   <= S_FIN;
                    end
                end
                S_LOAD: r_state <= S_EMIT;
                S_EMIT: begin
                    r_res_duty  <= ser_duty;
                    r_res_valid <= 1'b1;
                    r_res_done  <= ser_sts.last;
                    if (ser_sts.last) begin
                        r_sending <= 1'b0;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    // Hand the result over once the output register is free.
                    if (!o_valid || !i_stall) begin
                        o_valid      <= 1'b1;
                        o_slot_duty  <= r_res_duty;
                        o_slot_valid <= r_res_valid;
                        o_frame_done <= r_res_done;
                        o_busy_flag  <= r_sending;
                        o_accepted   <= r_res_acc;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A frame's last slot always reports the string as no longer busy.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_frame_done && o_busy_flag))
        else $error("frame done reported while still busy");

    // An emitted slot only comes from an accepted item.
    a_slot_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_slot_valid) |-> o_accepted)
        else $error("slot emitted by a rejected item");

    // Sending starts only at the end of a full frame copy.
    a_send_after_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sending) |-> ($past(r_state) == S_COPY))
        else $error("sending started without a frame copy");

    // The copy sweep ends with sending set.
    a_copy_sets_send: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        copy_end |=> r_sending)
        else $error("frame copy finished but sending is clear");

endmodule

// ===== sim/tb_addressable_led_bit_slot_driver.sv =====
// Self-checking testbench for the LED bit-slot driver: directed, frame, live-config, random tests.
module tb_addressable_led_bit_slot_driver;
    timeunit 1ns;
    timeprecision 1ps;

    import ledd_pkg::*;

    // Function codes with no defined action, and the register index with no register behind it.
    localparam logic [2:0] FN_RSVD_LO = 3'd5;
    localparam logic [2:0] FN_RSVD_HI = 3'd7;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 25;
    localparam int CFG_SETTLE    = 4;
    localparam int PHASE_ITEMS   = 75;

    // One expected result transfer.
    typedef struct packed {
        logic [CFG_W-1:0] duty;
        logic             slot_valid;
        logic             frame_done;
        logic             busy;
        logic             accepted;
    } t_slot_result;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic [2:0] i_func        = FN_TICK;
    logic [7:0] i_pixel_index = 8'd0;
    logic [7:0] i_red         = 8'd0;
    logic [7:0] i_green       = 8'd0;
    logic [7:0] i_blue        = 8'd0;
    logic       i_stall       = 1'b0;
    logic       i_cfg_we      = 1'b0;
    logic [1:0] i_cfg_idx     = CFG_DUTY_ONE;
    logic [9:0] i_cfg_data    = 10'd0;
    logic       o_stall;
    logic       o_valid;
    logic [9:0] o_slot_duty;
    logic       o_slot_valid;
    logic       o_frame_done;
    logic       o_busy_flag;
    logic       o_accepted;

    // Predicted state of the driver.
    logic [GRB_W-1:0] pixels_m [LED_COUNT];
    logic [GRB_W-1:0] frame_m  [LED_COUNT];
    logic             sending_m;
    logic [12:0]      slot_pos_m;
    logic [CFG_W-1:0] duty_one_m;
    logic [CFG_W-1:0] duty_zero_m;
    logic [CFG_W-1:0] reset_slots_m;

    t_slot_result pending_slots_q[$];

    int n_errors     = 0;
    int n_items      = 0;
    int n_slots      = 0;
    int n_frames     = 0;
    int n_rejected   = 0;
    int n_cfg_writes = 0;
    int send_gap_pct = 0;
    int stall_pct    = 0;
    int idle_cycles  = 0;

    addressable_led_bit_slot_driver u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_func        (i_func),
        .i_pixel_index (i_pixel_index),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_slot_duty   (o_slot_duty),
        .o_slot_valid  (o_slot_valid),
        .o_frame_done  (o_frame_done),
        .o_busy_flag   (o_busy_flag),
        .o_accepted    (o_accepted),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Predict the result of one item and advance the predicted state.
    function automatic t_slot_result predict_slot(input logic [2:0] func, input logic [7:0] idx,
                                                  input logic [7:0] red, input logic [7:0] green,
                                                  input logic [7:0] blue);
        t_slot_result     res;
        logic [GRB_W-1:0] grb;
        int               frame_len;
        int               bit_ofs;
        res          = '0;
        res.accepted = 1'b1;
        grb          = {green, red, blue};
        case (func)
            FN_WRITE: begin
                if (idx < LED_COUNT) pixels_m[idx] = grb;
                else res.accepted = 1'b0;
            end
            FN_FILL: begin
                for (int i = 0; i < LED_COUNT; i++) pixels_m[i] = grb;
            end
            FN_CLEAR: begin
                for (int i = 0; i < LED_COUNT; i++) pixels_m[i] = '0;
            end
            FN_START: begin
                if (sending_m) begin
                    res.accepted = 1'b0;
                end else begin
                    frame_m    = pixels_m;
                    sending_m  = 1'b1;
                    slot_pos_m = '0;
                end
            end
            FN_TICK: begin
                if (sending_m) begin
                    // Data slots walk the frame copy G, R, B, MSB first; the tail is all zero.
                    frame_len = DATA_SLOTS + int'(reset_slots_m);
                    if (int'(slot_pos_m) < DATA_SLOTS) begin
                        bit_ofs  = int'(slot_pos_m) % BITS_PER_LED;
                        res.duty = frame_m[int'(slot_pos_m) / BITS_PER_LED][GRB_W-1-bit_ofs] ?
                                   duty_one_m : duty_zero_m;
                    end
                    res.slot_valid = 1'b1;
                    if (int'(slot_pos_m) + 1 >= frame_len) begin
                        res.frame_done = 1'b1;
                        sending_m      = 1'b0;
                        slot_pos_m     = '0;
                    end else begin
                        slot_pos_m = slot_pos_m + 1'b1;
                    end
                end
            end
            default: begin
                res.accepted = 1'b0;
            end
        endcase
        res.busy = sending_m;
        return res;
    endfunction

    function automatic logic [7:0] rand8();
        return 8'($urandom_range(255));
    endfunction

    // Mostly valid LED positions, sometimes anything the field can hold.
    function automatic logic [7:0] pick_index();
        if ($urandom_range(99) < 80) return 8'($urandom_range(LED_COUNT - 1));
        return rand8();
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            n_errors++;
            $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Send one item, wait for its transfer and record what it should produce.
    task automatic send_item(input logic [2:0] func, input logic [7:0] idx, input logic [7:0] red,
                             input logic [7:0] green, input logic [7:0] blue);
        t_slot_result res;
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_func        <= func;
        i_pixel_index <= idx;
        i_red         <= red;
        i_green       <= green;
        i_blue        <= blue;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        res = predict_slot(func, idx, red, green, blue);
        pending_slots_q.push_back(res);
        n_items++;
        n_slots    += res.slot_valid;
        n_frames   += res.frame_done;
        n_rejected += !res.accepted;
    endtask

    task automatic send_tick();
        send_item(FN_TICK, rand8(), rand8(), rand8(), rand8());
    endtask

    // Hold the sender off until every outstanding result has been received.
    task automatic wait_drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_slots_q.size() != 0);
    endtask

    // Register writes happen only with nothing in flight.
    task automatic cfg_write(input logic [1:0] idx, input logic [CFG_W-1:0] data);
        wait_drain();
        repeat (CFG_SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_DUTY_ONE:    duty_one_m    = data;
            CFG_DUTY_ZERO:   duty_zero_m   = data;
            CFG_RESET_SLOTS: reset_slots_m = data;
            default: ;
        endcase
        n_cfg_writes++;
    endtask

    task automatic set_config(input logic [CFG_W-1:0] one, input logic [CFG_W-1:0] zero,
                              input logic [CFG_W-1:0] slots);
        cfg_write(CFG_DUTY_ONE, one);
        cfg_write(CFG_DUTY_ZERO, zero);
        cfg_write(CFG_RESET_SLOTS, slots);
    endtask

    // Start a frame and tick until it has been sent out completely.
    task automatic run_frame();
        send_item(FN_START, rand8(), rand8(), rand8(), rand8());
        while (sending_m) send_tick();
    endtask

    // Field extremes, every function code and the rejection cases.
    task automatic test_directed();
        send_gap_pct = 0;
        stall_pct    = 0;
        send_tick();
        send_item(FN_WRITE, 8'd0, 8'h00, 8'hFF, 8'hFF);
        send_item(FN_WRITE, 8'(LED_COUNT - 1), 8'hFF, 8'hFF, 8'hFF);
        send_item(FN_WRITE, 8'(LED_COUNT), 8'h12, 8'h34, 8'h56);
        send_item(FN_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        for (int f = int'(FN_RSVD_LO); f <= int'(FN_RSVD_HI); f++) begin
            send_item(3'(f), rand8(), rand8(), rand8(), rand8());
        end
        send_item(FN_FILL, rand8(), 8'h00, 8'h00, 8'h00);
        send_item(FN_FILL, rand8(), 8'hFF, 8'hFF, 8'hFF);
        send_item(FN_CLEAR, rand8(), rand8(), rand8(), rand8());
        send_item(FN_WRITE, 8'd3, 8'hA5, 8'h5A, 8'h3C);
        send_item(FN_START, rand8(), rand8(), rand8(), rand8());
        // A second start during a frame is refused.
        send_item(FN_START, rand8(), rand8(), rand8(), rand8());
        repeat (3) send_tick();
        // Store changes during a frame must not reach the frame already running.
        send_item(FN_WRITE, 8'd3, 8'h00, 8'h00, 8'h00);
        send_item(FN_FILL, rand8(), 8'hFF, 8'hFF, 8'hFF);
        send_item(FN_CLEAR, rand8(), rand8(), rand8(), rand8());
        repeat (2) send_tick();
    endtask

    // A whole frame at the duty extremes with an empty reset tail.
    task automatic test_full_frames();
        send_gap_pct = 38;
        stall_pct    = 38;
        while (sending_m) send_tick();
        set_config(10'h3FF, 10'h000, 10'd0);
        for (int i = 0; i < LED_COUNT; i++) send_item(FN_WRITE, 8'(i), rand8(), rand8(), rand8());
        run_frame();
    endtask

    // Register changes that land in the middle of a frame.
    task automatic test_live_config();
        send_gap_pct = 0;
        stall_pct    = 0;
        set_config(DUTY_ONE_RST, DUTY_ZERO_RST, 10'd20);
        send_item(FN_FILL, rand8(), rand8(), rand8(), rand8());
        send_item(FN_START, rand8(), rand8(), rand8(), rand8());
        repeat (100) send_tick();
        cfg_write(CFG_DUTY_ONE, 10'h3FF);
        cfg_write(CFG_DUTY_ZERO, 10'h001);
        repeat (295) send_tick();
        // The slot position is now past the shortened frame, so the next tick ends it.
        cfg_write(CFG_RESET_SLOTS, 10'd0);
        cfg_write(CFG_UNUSED, 10'($urandom_range(1023)));
        repeat (2) send_tick();
    endtask

    // Random frames with store traffic and noise mixed in, under one idling mix.
    task automatic test_random(input int gap_pct, input int stall_p);
        int pick;
        send_gap_pct = gap_pct;
        stall_pct    = stall_p;
        set_config(10'($urandom_range(1023)), 10'($urandom_range(1023)),
                   10'($urandom_range(24)));
        for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (k % 40 == 39) wait_drain();
            pick = $urandom_range(99);
            if (sending_m) begin
                if (pick < 88) send_tick();
                else if (pick < 90) send_item(FN_START, rand8(), rand8(), rand8(), rand8());
                else if (pick < 97) send_item(FN_WRITE, pick_index(), rand8(), rand8(), rand8());
                else send_item(3'($urandom_range(7)), rand8(), rand8(), rand8(), rand8());
            end else begin
                if (pick < 35) send_item(FN_WRITE, pick_index(), rand8(), rand8(), rand8());
                else if (pick < 45) send_item(FN_FILL, rand8(), rand8(), rand8(), rand8());
                else if (pick < 50) send_item(FN_CLEAR, rand8(), rand8(), rand8(), rand8());
                else if (pick < 70) send_item(FN_START, rand8(), rand8(), rand8(), rand8());
                else if (pick < 92) send_tick();
                else send_item(3'($urandom_range(7)), rand8(), rand8(), rand8(), rand8());
            end
        end
    endtask

    // Receiver side stalls at random.
    always @(posedge i_clk) begin
        i_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // Compare every result transfer with the oldest pending prediction.
    always @(posedge i_clk) begin : result_check
        t_slot_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_slots_q.size() == 0) begin
                n_errors++;
                $display("%0t unexpected result transfer: duty %0d valid %0b done %0b", $time,
                         o_slot_duty, o_slot_valid, o_frame_done);
            end else begin
                want = pending_slots_q.pop_front();
                check_field("slot_duty", want.duty, o_slot_duty);
                check_field("slot_valid", want.slot_valid, o_slot_valid);
                check_field("frame_done", want.frame_done, o_frame_done);
                check_field("busy_flag", want.busy, o_busy_flag);
                check_field("accepted", want.accepted, o_accepted);
            end
        end
    end

    // Stop the run if no transfer happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t timeout: no transfer for %0d cycles", $time, IDLE_LIMIT);
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Test sequence.
    initial begin
        for (int i = 0; i < LED_COUNT; i++) begin
            pixels_m[i] = '0;
            frame_m[i]  = '0;
        end
        sending_m     = 1'b0;
        slot_pos_m    = '0;
        duty_one_m    = DUTY_ONE_RST;
        duty_zero_m   = DUTY_ZERO_RST;
        reset_slots_m = RESET_SLOTS_RST;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_frames();
        test_live_config();
        test_random(0, 0);
        test_random(68, 0);
        test_random(0, 68);
        test_random(38, 38);

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Sent %0d items: %0d bit slots emitted, %0d frames completed, %0d items refused.",
                 n_items, n_slots, n_frames, n_rejected);
        $display("Made %0d register writes over default, extreme and random settings.",
                 n_cfg_writes);
        if (n_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
